### sv/dms_angle_string_parser_unit_macros.svh
// Assertion macros for the angle string parser checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef DMS_ANGLE_STRING_PARSER_UNIT_MACROS_SVH
`define DMS_ANGLE_STRING_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define DASP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dasp check failed");

// next-cycle implication
`define DASP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dasp check failed");

`endif

### sv/dasp_pkg.sv
// Package for the angle string parser: character codes, register indexes,
// field widths and the numeric field converter. No dependencies.
package dasp_pkg;

	localparam int STORE_DEPTH = 9;
	localparam int COUNT_W     = 4;
	localparam int ANGLE_W     = 22;
	localparam int MAG_W       = 10;

	localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd10;
	localparam logic [COUNT_W-1:0] LEN_SHORT = 4'd6;
	localparam logic [COUNT_W-1:0] LEN_LONG  = 4'd9;

	localparam logic [0:0] REG_SIGN_REQUIRED  = 1'b0;
	localparam logic [0:0] REG_HIGH_PRECISION = 1'b1;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DEG   = 8'hDF;
	localparam logic [7:0] CH_TICK  = 8'h27;
	localparam logic [7:0] CH_NONE  = 8'h00;

	localparam logic [MAG_W-1:0] DEG_MAX_SIGNED = 10'd90;
	localparam logic [MAG_W-1:0] DEG_MAX        = 10'd360;
	localparam logic [MAG_W-1:0] MINSEC_MAX     = 10'd59;

	localparam logic signed [ANGLE_W-1:0] ARCSEC_PER_DEG = 22'sd3600;
	localparam logic [11:0]               ARCSEC_PER_MIN = 12'd60;

	typedef enum logic [1:0] {
		PH_WS,
		PH_SIGN,
		PH_DIGIT,
		PH_DONE
	} conv_phase_t;

	typedef struct packed {
		logic             ok;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} conv_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[CH_ZERO:CH_NINE]};
	endfunction

	// strtol-style conversion of up to three bytes; pad short fields with CH_NONE
	function automatic conv_t conv_field(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2);
		logic [7:0]       bs [3];
		logic [7:0]       c;
		conv_phase_t      ph;
		logic             used;
		logic             neg;
		logic             any;
		logic [MAG_W-1:0] acc;
		conv_t            r;
		bs[0] = b0;
		bs[1] = b1;
		bs[2] = b2;
		ph    = PH_WS;
		neg   = 1'b0;
		any   = 1'b0;
		acc   = '0;
		for (int i = 0; i < 3; i++) begin
			c    = bs[i];
			used = 1'b0;
			if (ph == PH_WS) begin
				if (is_ws(c)) begin
					used = 1'b1;
				end else begin
					ph = PH_SIGN;
				end
			end
			if (!used && ph == PH_SIGN) begin
				ph = PH_DIGIT;
				if (c == CH_PLUS || c == CH_MINUS) begin
					neg  = (c == CH_MINUS);
					used = 1'b1;
				end
			end
			if (!used && ph == PH_DIGIT) begin
				if (is_digit(c)) begin
					acc = MAG_W'((acc << 3) + (acc << 1) + {6'b0, c[3:0]});
					any = 1'b1;
				end else begin
					ph = PH_DONE;
				end
			end
		end
		r.ok  = any;
		r.neg = neg;
		r.mag = acc;
		return r;
	endfunction

endpackage

### sv/dms_angle_string_parser_unit.sv
// Angle string parser (degrees, minutes, optional seconds) with APB setup.
// Depends on dasp_pkg.
//
// Usage:
//  - s_axis carries one character per request in tdata, tlast marks the
//    final character of the string. Leading spaces are dropped.
//  - On the final character one result leaves on m_axis: tdata[0] is the
//    accept flag, tdata[22:1] the signed arcsecond count (zero on reject).
//    Characters that are not last produce no result.
//  - A result reaches m_axis through the input register and then the result
//    register, which loads when its last character leaves the input
//    register.
//  - Throughput: one character per cycle but for the stall below, set by the
//    single evaluation stage between the input register and the result register.
//  - A stalled m_axis holds its result; the input register still takes
//    characters that do not end a string, and stalls only behind a last
//    character while the result register is full.
//  - The APB port sets sign_required (0x0) and high_precision (0x4); write
//    it only while no string is in flight.
//  - Reset clears both registers, the character count and both valid
//    flags; the character store needs no clearing.
module dms_angle_string_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [0] parse_ok, [22:1] angle_arcsec, [23] zero
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = dasp_pkg::ANGLE_W;
	localparam int CW = dasp_pkg::COUNT_W;

	logic sign_required_q;
	logic high_precision_q;

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       advance_s1;

	logic          skip_q;
	logic [CW-1:0] count_q;
	logic [7:0]    store_q [dasp_pkg::STORE_DEPTH];

	logic          out_valid_q;
	logic          parse_ok_q;
	logic [AW-1:0] angle_q;

	logic          out_free;
	logic          wr_store;
	logic [CW-1:0] count_next;
	logic [7:0]    e [dasp_pkg::STORE_DEPTH];

	dasp_pkg::conv_t deg_c;
	dasp_pkg::conv_t min_c;
	dasp_pkg::conv_t sec_c;

	logic                 len_ok;
	logic                 sign_ok;
	logic                 sgn_neg;
	logic                 sep1_ok;
	logic                 sep2_ok;
	logic                 deg_ok;
	logic                 min_ok;
	logic                 sec_ok;
	logic                 all_ok;
	logic [5:0]           sec_v;
	logic [11:0]          ms_v;
	logic signed [AW-1:0] deg_v;
	logic signed [AW-1:0] sum_v;
	logic signed [AW-1:0] ang_v;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sign_required_q  <= 1'b0;
			high_precision_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == dasp_pkg::REG_SIGN_REQUIRED) begin
				sign_required_q <= pwdata[0];
			end else begin
				high_precision_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == dasp_pkg::REG_SIGN_REQUIRED) begin
			prdata[0] = sign_required_q;
		end else begin
			prdata[0] = high_precision_q;
		end
	end

	// input register
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance_s1    = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// character store and count
	assign wr_store = valid_s1 && !(skip_q && char_s1 == dasp_pkg::CH_SPACE);

	always_comb begin
		count_next = count_q;
		if (wr_store && count_q != dasp_pkg::COUNT_SAT) begin
			count_next = CW'(count_q + 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q  <= 1'b1;
			count_q <= '0;
		end else if (advance_s1) begin
			if (last_s1) begin
				skip_q  <= 1'b1;
				count_q <= '0;
			end else begin
				if (wr_store) begin
					skip_q <= 1'b0;
				end
				count_q <= count_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && wr_store && count_q < CW'(dasp_pkg::STORE_DEPTH)) begin
			store_q[count_q] <= char_s1;
		end
	end

	// evaluate the string including the character in the input register
	always_comb begin
		for (int i = 0; i < dasp_pkg::STORE_DEPTH; i++) begin
			e[i] = (wr_store && count_q == CW'(i)) ? char_s1 : store_q[i];
		end
	end

	always_comb begin
		if (sign_required_q) begin
			deg_c = dasp_pkg::conv_field(e[1], e[2], dasp_pkg::CH_NONE);
		end else begin
			deg_c = dasp_pkg::conv_field(e[0], e[1], e[2]);
		end
		min_c = dasp_pkg::conv_field(e[4], e[5], dasp_pkg::CH_NONE);
		sec_c = dasp_pkg::conv_field(e[7], e[8], dasp_pkg::CH_NONE);

		if (high_precision_q) begin
			len_ok = (count_next == dasp_pkg::LEN_LONG);
		end else begin
			len_ok = (count_next == dasp_pkg::LEN_SHORT) || (count_next == dasp_pkg::LEN_LONG);
		end

		sign_ok = !sign_required_q || e[0] == dasp_pkg::CH_PLUS || e[0] == dasp_pkg::CH_MINUS;
		sgn_neg = sign_required_q && e[0] == dasp_pkg::CH_MINUS;
		sep1_ok = e[3] inside {dasp_pkg::CH_COLON, dasp_pkg::CH_STAR, dasp_pkg::CH_DEG};
		sep2_ok = !high_precision_q || e[6] inside {dasp_pkg::CH_COLON, dasp_pkg::CH_TICK};

		if (sign_required_q) begin
			deg_ok = deg_c.ok && deg_c.mag <= dasp_pkg::DEG_MAX_SIGNED;
		end else begin
			deg_ok = deg_c.ok && (deg_c.neg ? deg_c.mag == '0 : deg_c.mag <= dasp_pkg::DEG_MAX);
		end
		min_ok = min_c.ok && (min_c.neg ? min_c.mag == '0 : min_c.mag <= dasp_pkg::MINSEC_MAX);
		sec_ok = !high_precision_q || !sec_c.ok ||
			(sec_c.neg ? sec_c.mag == '0 : sec_c.mag <= dasp_pkg::MINSEC_MAX);

		all_ok = len_ok && sign_ok && sep1_ok && sep2_ok && deg_ok && min_ok && sec_ok;

		sec_v = (high_precision_q && sec_c.ok) ? sec_c.mag[5:0] : 6'd0;
		ms_v  = 12'({6'b0, min_c.mag[5:0]} * dasp_pkg::ARCSEC_PER_MIN) + {6'b0, sec_v};
		deg_v = deg_c.neg ? -signed'(AW'(deg_c.mag)) : signed'(AW'(deg_c.mag));
		sum_v = AW'(deg_v * dasp_pkg::ARCSEC_PER_DEG) + signed'(AW'(ms_v));
		ang_v = sgn_neg ? -sum_v : sum_v;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && last_s1) begin
			parse_ok_q <= all_ok;
			angle_q    <= all_ok ? ang_v : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, angle_q, parse_ok_q};

endmodule

### sv/dasp_chk.sv
// Port-level checker for the angle string parser, bound to the top level.
// Depends on dms_angle_string_parser_unit_macros.svh.
`include "dms_angle_string_parser_unit_macros.svh"

module dasp_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        psel,
	input logic        pready
);

	// hold a stalled result
	`DASP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))

	// drop the angle of a rejected string
	`DASP_ASSERT_NOW(a_reject_zero, m_axis_tvalid && !m_axis_tdata[0],
		m_axis_tdata[22:1] == 22'd0)

	// a fresh result follows an accepted last character
	`DASP_ASSERT_NOW(a_no_spurious, $rose(m_axis_tvalid),
		$past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))

	// padding bit stays clear
	`DASP_ASSERT_NOW(a_pad_zero, m_axis_tvalid, !m_axis_tdata[23])

	// the configuration port never waits
	`DASP_ASSERT_NOW(a_pready, psel, pready)

endmodule

bind dms_angle_string_parser_unit dasp_chk u_dasp_chk (.*);
